[rtl/assert_macros.svh]
// Assertion macros shared by the integer format text engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define IFTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define IFTE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/ifte_pkg.sv]
// Package with types, constants and helper functions of the integer format text engine.
package ifte_pkg;

  localparam int MaxWidth   = 64;
  localparam int WidthW     = $clog2(MaxWidth + 1);
  localparam int DecCap     = 10;
  localparam int DecDigits  = 10;
  localparam int HexNibbles = 8;
  localparam int BinW       = 32;
  localparam int DigitsW    = 4 * DecDigits;
  localparam int StepW      = $clog2(BinW);
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChOne     = 8'h31;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChLowerD  = 8'h64;
  localparam logic [7:0] ChLowerU  = 8'h75;
  localparam logic [7:0] ChLowerX  = 8'h78;
  localparam logic [7:0] ChUpperX  = 8'h58;
  localparam logic [7:0] ChQuery   = 8'h3F;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChLowerA  = 8'h61;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_DEC,
    CMD_HEX
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_PREP,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [7:0]         ch;
    logic [BinW-1:0]    arg;
    logic               is_signed;
    logic               upper;
    logic               zero_pad;
    logic [WidthW-1:0]  width;
  } cmd_t;

  function automatic logic [WidthW-1:0] grow_width(logic [WidthW-1:0] w, logic [3:0] digit);
    logic [WidthW+3:0] v;
    v = {4'b0000, w} * (WidthW + 4)'(10) + (WidthW + 4)'(digit);
    return (v > (WidthW + 4)'(MaxWidth)) ? WidthW'(MaxWidth) : v[WidthW-1:0];
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] d, logic upper);
    logic [7:0] base;
    base = upper ? ChUpperA : ChLowerA;
    return (d < 4'd10) ? ChZero + {4'b0000, d} : base + {4'b0000, d} - 8'd10;
  endfunction

endpackage

[rtl/ifte_front.sv]
// Front part: parses format characters and queues output commands.
module ifte_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            format_char_i,
  input  logic [31:0]           arg_value_i,
  input  logic                  q_full_i,
  output logic                  q_wr_o,
  output ifte_pkg::cmd_t        q_cmd_o
);
  import ifte_pkg::*;

  logic                in_spec_q, in_spec_d;
  logic                zero_q, zero_d;
  logic [WidthW-1:0]   width_q, width_d;
  logic                accept;

  assign full   = q_full_i;
  assign accept = push & ~q_full_i;

  always_comb begin
    in_spec_d = in_spec_q;
    zero_d    = zero_q;
    width_d   = width_q;
    q_wr_o    = 1'b0;
    q_cmd_o.kind      = CMD_CHAR;
    q_cmd_o.ch        = format_char_i;
    q_cmd_o.arg       = arg_value_i;
    q_cmd_o.is_signed = (format_char_i == ChLowerD);
    q_cmd_o.upper     = (format_char_i == ChUpperX);
    q_cmd_o.zero_pad  = zero_q;
    q_cmd_o.width     = width_q;
    if (accept) begin
      if (format_char_i == ChNul) begin
        in_spec_d = 1'b0;
        zero_d    = 1'b0;
        width_d   = '0;
      end else if (!in_spec_q) begin
        if (format_char_i == ChPercent) begin
          in_spec_d = 1'b1;
        end else begin
          q_wr_o = 1'b1;
        end
      end else if (format_char_i == ChZero) begin
        if (width_q != '0 || zero_q) begin
          width_d = grow_width(width_q, 4'd0);
        end else begin
          zero_d = 1'b1;
        end
      end else if (format_char_i >= ChOne && format_char_i <= ChNine) begin
        width_d = grow_width(width_q, 4'(format_char_i - ChZero));
      end else begin
        q_wr_o = 1'b1;
        if (format_char_i == ChLowerD || format_char_i == ChLowerU) begin
          q_cmd_o.kind = CMD_DEC;
        end else if (format_char_i == ChLowerX || format_char_i == ChUpperX) begin
          q_cmd_o.kind = CMD_HEX;
        end else if (format_char_i == ChPercent) begin
          q_cmd_o.ch = ChPercent;
        end else begin
          q_cmd_o.ch = ChQuery;
        end
        in_spec_d = 1'b0;
        zero_d    = 1'b0;
        width_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_spec_q <= 1'b0;
      zero_q    <= 1'b0;
      width_q   <= '0;
    end else begin
      in_spec_q <= in_spec_d;
      zero_q    <= zero_d;
      width_q   <= width_d;
    end
  end

endmodule

[rtl/ifte_cmd_queue.sv]
// Short command queue between the front and back parts.
`include "assert_macros.svh"
module ifte_cmd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  ifte_pkg::cmd_t  wr_cmd_i,
  output logic            full_o,
  input  logic            rd_i,
  output ifte_pkg::cmd_t  rd_cmd_o,
  output logic            empty_o
);
  import ifte_pkg::*;

  cmd_t                  mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]  cnt_q, cnt_d;
  logic                  do_wr, do_rd;

  assign full_o   = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o  = (cnt_q == '0);
  assign do_wr    = wr_i & ~full_o;
  assign do_rd    = rd_i & ~empty_o;
  assign rd_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  `IFTE_NEVER(a_no_write_when_full, wr_i && full_o, "command written into a full queue")

endmodule

[rtl/ifte_back.sv]
// Back part: converts numbers to digits and emits characters into the output register.
`include "assert_macros.svh"
module ifte_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ifte_pkg::cmd_t  cmd_i,
  input  logic            cmd_empty_i,
  output logic            cmd_pop_o,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_char_o,
  output logic            last_of_run_o
);
  import ifte_pkg::*;

  back_state_e          state_q, state_d;
  logic                 upper_q, upper_d;
  logic                 zp_q, zp_d;
  logic                 dec_q, dec_d;
  logic                 neg_q, neg_d;
  logic [WidthW-1:0]    width_q, width_d;
  logic [BinW-1:0]      bin_q, bin_d;
  logic [DigitsW-1:0]   digits_q, digits_d;
  logic [StepW-1:0]     step_q, step_d;
  logic [WidthW-1:0]    len_q, len_d;
  logic [WidthW-1:0]    content_q, content_d;
  logic [WidthW-1:0]    r_q, r_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_char_q, out_char_d;
  logic                 out_last_q, out_last_d;

  logic                 out_free;
  logic [DigitsW-1:0]   adj;
  logic [WidthW-1:0]    nsig, w_eff, body, hex_min;
  logic [DigitsW-1:0]   digit_shift;
  logic                 is_neg;

  assign out_free      = ~out_valid_q | pop;
  assign empty         = ~out_valid_q;
  assign out_char_o    = out_char_q;
  assign last_of_run_o = out_last_q;
  assign is_neg        = cmd_i.is_signed & cmd_i.arg[BinW-1];
  assign digit_shift   = digits_q >> {r_q[3:0], 2'b00};

  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      adj[4*i +: 4] = (digits_q[4*i +: 4] >= 4'd5) ? digits_q[4*i +: 4] + 4'd3
                                                   : digits_q[4*i +: 4];
    end
  end

  always_comb begin
    nsig = WidthW'(1);
    for (int i = 0; i < DecDigits; i++) begin
      if (digits_q[4*i +: 4] != 4'd0) begin
        nsig = WidthW'(i + 1);
      end
    end
    if (width_q == '0) begin
      w_eff = WidthW'(1);
    end else if (dec_q && width_q > WidthW'(DecCap)) begin
      w_eff = WidthW'(DecCap);
    end else begin
      w_eff = width_q;
    end
    hex_min = (w_eff > WidthW'(HexNibbles)) ? WidthW'(HexNibbles) : w_eff;
    if (dec_q) begin
      body = (zp_q && w_eff > nsig) ? w_eff : nsig;
    end else begin
      body = (zp_q && hex_min > nsig) ? hex_min : nsig;
    end
  end

  always_comb begin
    state_d     = state_q;
    upper_d     = upper_q;
    zp_d        = zp_q;
    dec_d       = dec_q;
    neg_d       = neg_q;
    width_d     = width_q;
    bin_d       = bin_q;
    digits_d    = digits_q;
    step_d      = step_q;
    len_d       = len_q;
    content_d   = content_q;
    r_d         = r_q;
    out_valid_d = out_valid_q & ~pop;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    cmd_pop_o   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          if (cmd_i.kind == CMD_CHAR) begin
            if (out_free) begin
              cmd_pop_o   = 1'b1;
              out_valid_d = 1'b1;
              out_char_d  = cmd_i.ch;
              out_last_d  = 1'b1;
            end
          end else begin
            cmd_pop_o = 1'b1;
            upper_d   = cmd_i.upper;
            zp_d      = cmd_i.zero_pad;
            width_d   = cmd_i.width;
            step_d    = '0;
            if (cmd_i.kind == CMD_DEC) begin
              dec_d    = 1'b1;
              neg_d    = is_neg;
              bin_d    = is_neg ? (~cmd_i.arg + 1'b1) : cmd_i.arg;
              digits_d = '0;
              state_d  = BK_CONV;
            end else begin
              dec_d    = 1'b0;
              neg_d    = 1'b0;
              digits_d = DigitsW'(cmd_i.arg);
              state_d  = BK_PREP;
            end
          end
        end
      end
      BK_CONV: begin
        digits_d = {adj[DigitsW-2:0], bin_q[BinW-1]};
        bin_d    = {bin_q[BinW-2:0], 1'b0};
        step_d   = step_q + 1'b1;
        if (step_q == StepW'(BinW - 1)) begin
          state_d = BK_PREP;
        end
      end
      BK_PREP: begin
        content_d = body + WidthW'(neg_q);
        len_d     = (w_eff > content_d) ? w_eff : content_d;
        r_d       = len_d - 1'b1;
        state_d   = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = (r_q == '0);
          if (r_q >= content_q) begin
            out_char_d = ChSpace;
          end else if (neg_q && r_q == content_q - 1'b1) begin
            out_char_d = ChMinus;
          end else begin
            out_char_d = hex_char(digit_shift[3:0], upper_q);
          end
          if (r_q == '0) begin
            state_d = BK_IDLE;
          end else begin
            r_d = r_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    upper_q    <= upper_d;
    zp_q       <= zp_d;
    dec_q      <= dec_d;
    neg_q      <= neg_d;
    width_q    <= width_d;
    bin_q      <= bin_d;
    digits_q   <= digits_d;
    step_q     <= step_d;
    len_q      <= len_d;
    content_q  <= content_d;
    r_q        <= r_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  `IFTE_ASSERT(a_emit_index_in_range, state_q == BK_EMIT |-> r_q < len_q, "emit index beyond run length")
  `IFTE_ASSERT(a_content_fits, state_q == BK_EMIT |-> (content_q != '0 && content_q <= len_q), "digit content does not fit the run")
  `IFTE_ASSERT(a_pop_only_idle, cmd_pop_o |-> state_q == BK_IDLE, "command taken while busy")
  `IFTE_ASSERT(a_run_ends_last, (state_q == BK_EMIT && out_free && r_q == '0) |=> (out_valid_q && out_last_q && state_q == BK_IDLE), "run did not end with a last character")

endmodule

[rtl/integer_format_text_engine.sv]
// A plain character passes through the command queue into the output register; a hex
// conversion runs the prepare and emit states, a decimal one first runs the conversion state.
// Throughput: one plain character per cycle while the output is taken and the back part is idle;
// a conversion holds the back part for digits (32 double-dabble steps for decimal), a prepare
// state, up to 64 characters (one per cycle while output is popped) and idle for the next command.
// Reset is asynchronous, active low: plain text mode, width zero, command queue and output empty.
module integer_format_text_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  format_char_i,
  input  logic [31:0] arg_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char_o,
  output logic        last_of_run_o
);
  import ifte_pkg::*;

  cmd_t  wr_cmd, rd_cmd;
  logic  q_wr, q_full, q_rd, q_empty;

  ifte_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .format_char_i (format_char_i),
    .arg_value_i   (arg_value_i),
    .q_full_i      (q_full),
    .q_wr_o        (q_wr),
    .q_cmd_o       (wr_cmd)
  );

  ifte_cmd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_cmd_i (wr_cmd),
    .full_o   (q_full),
    .rd_i     (q_rd),
    .rd_cmd_o (rd_cmd),
    .empty_o  (q_empty)
  );

  ifte_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (rd_cmd),
    .cmd_empty_i   (q_empty),
    .cmd_pop_o     (q_rd),
    .pop           (pop),
    .empty         (empty),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

[tb/testbench.sv]
// Self-checking testbench for the integer format text engine with a built-in formatter model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ifte_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_out_t;

  class text_scoreboard;
    text_out_t  pending_chars[$];
    logic       in_spec;
    logic       zero_pad;
    int unsigned width_acc;
    int unsigned mismatches;
    text_out_t  run[$];

    function void clear();
      in_spec = 0;
      zero_pad = 0;
      width_acc = 0;
      mismatches = 0;
      pending_chars.delete();
    endfunction

    function void put_char(logic [7:0] c);
      if (run.size() < 64) run.push_back('{ch: c, last: 1'b0});
    endfunction

    function int unsigned widen(int unsigned w, int unsigned d);
      int unsigned v;
      v = w * 10 + d;
      return (v > MaxWidth) ? MaxWidth : v;
    endfunction

    function void format_decimal(logic [31:0] n, logic sgn, logic zp, int unsigned w);
      logic [7:0] digits[$];
      logic neg;
      neg = 0;
      if (w == 0) w = 1;
      if (w > DecCap) w = DecCap;
      if (sgn && n[31]) begin
        neg = 1;
        n = ~n + 1;
      end
      do begin
        digits.push_front(ChZero + 8'(n % 10));
        n = n / 10;
      end while (n != 0);
      if (zp) while (digits.size() < w) digits.push_front(ChZero);
      if (neg) digits.push_front(ChMinus);
      for (int i = digits.size(); i < w; i++) put_char(ChSpace);
      foreach (digits[i]) put_char(digits[i]);
    endfunction

    function void format_hex(logic [31:0] n, logic up, logic zp, int unsigned w);
      logic started;
      logic [3:0] d;
      started = 0;
      if (w == 0) w = 1;
      for (int p = 7; p >= 0; p--) begin
        d = n[p*4 +: 4];
        if (started || (zp && w > p) || d != 0 || p == 0) begin
          if (!started) begin
            started = 1;
            while (w > p + 1) begin
              put_char(ChSpace);
              w--;
            end
          end
          if (d < 10) put_char(ChZero + 8'(d));
          else put_char((up ? ChUpperA : ChLowerA) + 8'(d) - 8'd10);
        end
      end
    endfunction

    function void note_transfer(logic [7:0] c, logic [31:0] arg);
      run.delete();
      if (c == ChNul) begin
        in_spec = 0;
        zero_pad = 0;
        width_acc = 0;
      end else if (!in_spec) begin
        if (c == ChPercent) in_spec = 1;
        else put_char(c);
      end else if (c == ChZero) begin
        if (width_acc != 0 || zero_pad) width_acc = widen(width_acc, 0);
        else zero_pad = 1;
      end else if (c >= ChOne && c <= ChNine) begin
        width_acc = widen(width_acc, c - ChZero);
      end else begin
        if (c == ChLowerD || c == ChLowerU) format_decimal(arg, c == ChLowerD, zero_pad, width_acc);
        else if (c == ChLowerX || c == ChUpperX) format_hex(arg, c == ChUpperX, zero_pad, width_acc);
        else if (c == ChPercent) put_char(ChPercent);
        else put_char(ChQuery);
        in_spec = 0;
        zero_pad = 0;
        width_acc = 0;
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) pending_chars.push_back(run[i]);
    endfunction

    function void check_char(logic [7:0] c, logic l);
      text_out_t e;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected character %h last %b", c, l);
        return;
      end
      e = pending_chars.pop_front();
      if (e.ch !== c || e.last !== l) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected char %h last %b, got char %h last %b", e.ch, e.last, c, l);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        push = 0;
  logic        full;
  logic [7:0]  format_char_i = '0;
  logic [31:0] arg_value_i = '0;
  logic        empty;
  logic        pop = 0;
  logic [7:0]  out_char_o;
  logic        last_of_run_o;

  text_scoreboard sb = new();
  int unsigned send_idle_pct;
  int unsigned take_idle_pct;
  int unsigned quiet_cycles;

  integer_format_text_engine dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && push && !full) sb.note_transfer(format_char_i, arg_value_i);
    if (rst_ni && pop && !empty) sb.check_char(out_char_o, last_of_run_o);
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
    pop <= rst_ni && ($urandom_range(99) >= take_idle_pct);
  end

  task automatic send_char(logic [7:0] c, logic [31:0] arg);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(posedge clk_i);
    end
    push <= 1;
    format_char_i <= c;
    arg_value_i <= arg;
    do @(posedge clk_i); while (full);
  endtask

  task automatic drain();
    push <= 0;
    do @(posedge clk_i); while (sb.pending_chars.size() != 0);
  endtask

  function automatic logic [31:0] rand_arg();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(999);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] rand_conv();
    case ($urandom_range(5))
      0: return ChLowerD;
      1: return ChLowerU;
      2: return ChLowerX;
      3: return ChUpperX;
      4: return ChPercent;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_spec();
    send_char(ChPercent, $urandom);
    if ($urandom_range(2) == 0) send_char(ChZero, $urandom);
    repeat ($urandom_range(2)) send_char(ChZero + 8'($urandom_range(9)), $urandom);
    send_char(rand_conv(), rand_arg());
  endtask

  task automatic send_phase(int unsigned n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: send_char(8'($urandom_range(255)), $urandom);
        2: send_char(ChNul, $urandom);
        default: send_spec();
      endcase
    end
  endtask

  initial begin
    sb.clear();
    quiet_cycles = 0;
    send_idle_pct = 26;
    take_idle_pct = 53;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_char(8'h41, 0);
    send_char(8'hFF, 0);
    send_char(8'h80, 0);
    send_char(ChPercent, 0); send_char(ChLowerD, 32'h8000_0000);
    send_char(ChPercent, 0); send_char(ChZero, 0); send_char(8'h35, 0);
    send_char(ChLowerD, 32'hFFFF_FFF9);
    send_char(ChPercent, 0); send_char(ChLowerU, 32'hFFFF_FFFF);
    send_char(ChPercent, 0); send_char(8'h39, 0); send_char(8'h39, 0);
    send_char(ChLowerX, 32'hABCD);
    send_char(ChPercent, 0); send_char(ChZero, 0); send_char(8'h31, 0);
    send_char(ChZero, 0); send_char(ChUpperX, 32'h1F);
    send_char(ChPercent, 0); send_char(ChPercent, 0);
    send_char(ChPercent, 0); send_char(8'h37, 0); send_char(8'h71, 0);
    send_char(ChPercent, 0); send_char(ChNul, 0);
    send_phase(50);
    send_idle_pct = 53;
    take_idle_pct = 26;
    drain();
    send_phase(50);
    send_idle_pct = 0;
    take_idle_pct = 0;
    send_phase(50);
    drain();
    repeat (100) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_chars.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/ifte_pkg.sv
rtl/ifte_front.sv
rtl/ifte_cmd_queue.sv
rtl/ifte_back.sv
rtl/integer_format_text_engine.sv
tb/testbench.sv
